// ===== design/ttp_pkg.sv =====
// Shared types, sizes and the 5x7 font for the text-to-page frame buffer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package ttp_pkg;

  // Display geometry.
  localparam int DISPLAY_COLUMNS = 128;
  localparam int DISPLAY_PAGES   = 8;
  localparam int STORE_BYTES     = DISPLAY_COLUMNS * DISPLAY_PAGES;
  localparam int ADDR_W          = $clog2(STORE_BYTES);

  // Character cell geometry.
  localparam int GLYPH_WIDTH = 5;
  localparam int CELL_WIDTH  = 6;
  localparam int GLYPH_BITS  = GLYPH_WIDTH * 8;
  localparam int STEP_W      = $clog2(CELL_WIDTH);
  localparam int FONT_IDX_W  = 6;

  // Largest cursor position at which a whole cell still fits.
  localparam int LAST_CELL_COL = DISPLAY_COLUMNS - CELL_WIDTH;

  // Request codes.
  localparam logic [1:0] REQ_TEXT  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] page;
    logic       line_start;
    logic [7:0] char_code;
    logic [6:0] column;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       drawn;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch a new request
    logic mem_clear;  // write zero at the sweep address and advance
    logic mem_draw;   // write the next cell column and advance
    logic mem_read;   // read the store at the held address
    logic out_load;   // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw_go;     // the offered request draws a character
    logic is_clear;    // the offered request clears the store
    logic is_read;     // the offered request reads a column byte
    logic sweep_last;  // the sweep address is at the last byte
    logic cell_last;   // the last column of the cell is being written
  } dp_status_t;

  // Maps a character code to its row of the font table.
  function automatic logic [FONT_IDX_W-1:0] font_row_of(input logic [7:0] code);
    logic [FONT_IDX_W-1:0] row;
    row = '0;
    if (code inside {[8'h30:8'h39]}) begin
      row = FONT_IDX_W'(code - 8'h30) + FONT_IDX_W'(6);
    end else if (code inside {[8'h41:8'h5A]}) begin
      row = FONT_IDX_W'(code - 8'h41) + FONT_IDX_W'(16);
    end else begin
      case (code)
        8'h2E:   row = FONT_IDX_W'(1);
        8'h3A:   row = FONT_IDX_W'(2);
        8'h2D:   row = FONT_IDX_W'(3);
        8'h2F:   row = FONT_IDX_W'(4);
        8'h25:   row = FONT_IDX_W'(5);
        default: row = '0;
      endcase
    end
    return row;
  endfunction

  // Five glyph columns, leftmost column in the top byte.
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [FONT_IDX_W-1:0] idx);
    logic [GLYPH_BITS-1:0] g;
    g = '0;
    case (idx)
      6'd1:    g = 40'h00_60_60_00_00;
      6'd2:    g = 40'h00_36_36_00_00;
      6'd3:    g = 40'h08_08_08_08_08;
      6'd4:    g = 40'h20_10_08_04_02;
      6'd5:    g = 40'h63_13_08_64_63;
      6'd6:    g = 40'h3E_51_49_45_3E;
      6'd7:    g = 40'h00_42_7F_40_00;
      6'd8:    g = 40'h42_61_51_49_46;
      6'd9:    g = 40'h21_41_45_4B_31;
      6'd10:   g = 40'h18_14_12_7F_10;
      6'd11:   g = 40'h27_45_45_45_39;
      6'd12:   g = 40'h3C_4A_49_49_30;
      6'd13:   g = 40'h01_71_09_05_03;
      6'd14:   g = 40'h36_49_49_49_36;
      6'd15:   g = 40'h06_49_49_29_1E;
      6'd16:   g = 40'h7E_11_11_11_7E;
      6'd17:   g = 40'h7F_49_49_49_36;
      6'd18:   g = 40'h3E_41_41_41_22;
      6'd19:   g = 40'h7F_41_41_22_1C;
      6'd20:   g = 40'h7F_49_49_49_41;
      6'd21:   g = 40'h7F_09_09_09_01;
      6'd22:   g = 40'h3E_41_49_49_7A;
      6'd23:   g = 40'h7F_08_08_08_7F;
      6'd24:   g = 40'h00_41_7F_41_00;
      6'd25:   g = 40'h20_40_41_3F_01;
      6'd26:   g = 40'h7F_08_14_22_41;
      6'd27:   g = 40'h7F_40_40_40_40;
      6'd28:   g = 40'h7F_02_0C_02_7F;
      6'd29:   g = 40'h7F_04_08_10_7F;
      6'd30:   g = 40'h3E_41_41_41_3E;
      6'd31:   g = 40'h7F_09_09_09_06;
      6'd32:   g = 40'h3E_41_51_21_5E;
      6'd33:   g = 40'h7F_09_19_29_46;
      6'd34:   g = 40'h46_49_49_49_31;
      6'd35:   g = 40'h01_01_7F_01_01;
      6'd36:   g = 40'h3F_40_40_40_3F;
      6'd37:   g = 40'h1F_20_40_20_1F;
      6'd38:   g = 40'h3F_40_38_40_3F;
      6'd39:   g = 40'h63_14_08_14_63;
      6'd40:   g = 40'h07_08_70_08_07;
      6'd41:   g = 40'h61_51_49_45_43;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== design/ttp_datapath.sv =====
// Datapath of the text-to-page frame buffer: frame store memory, text line state,
// glyph shifter, address counter and output register. Depends on ttp_pkg.
`default_nettype none

module ttp_datapath
  import ttp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_t        in_data,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output out_t            out_data
);

  localparam logic [8:0] LAST_CELL_9 = 9'(LAST_CELL_COL);

  logic [7:0] mem [STORE_BYTES];

  logic [7:0]            cursor_r, cursor_nxt;
  logic [2:0]            line_page_r, line_page_nxt;
  logic                  line_open_r, line_open_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [GLYPH_BITS-1:0] glyph_r;
  logic                  drawn_r;
  logic                  rd_ok_r;
  logic [7:0]            mem_q_r;
  out_t                  out_data_r;

  // Line state as seen by the offered request, after any line start.
  logic [7:0] cur_eff;
  logic [2:0] pg_eff;
  logic       open_eff;
  logic       is_text;
  logic       draw_go;
  logic [8:0] cur_adv;
  logic       rd_ok;
  logic [ADDR_W-1:0] draw_base;
  logic [ADDR_W-1:0] read_addr;

  always_comb begin
    is_text  = (in_data.req_type == REQ_TEXT);
    cur_eff  = in_data.line_start ? 8'd0 : cursor_r;
    pg_eff   = in_data.line_start ? in_data.page : line_page_r;
    open_eff = in_data.line_start ? (int'(in_data.page) < DISPLAY_PAGES) : line_open_r;
    draw_go  = is_text && open_eff && (in_data.char_code != 8'd0) &&
               ({1'b0, cur_eff} <= LAST_CELL_9);
    cur_adv  = {1'b0, cur_eff} + 9'(CELL_WIDTH);
    rd_ok    = (int'(in_data.page) < DISPLAY_PAGES) &&
               (int'(in_data.column) < DISPLAY_COLUMNS);
    draw_base = ADDR_W'(pg_eff) * ADDR_W'(DISPLAY_COLUMNS) + ADDR_W'(cur_eff);
    read_addr = ADDR_W'(in_data.page) * ADDR_W'(DISPLAY_COLUMNS) + ADDR_W'(in_data.column);
  end

  always_comb begin
    cursor_nxt    = cursor_r;
    line_page_nxt = line_page_r;
    line_open_nxt = line_open_r;
    addr_nxt      = addr_r;
    step_nxt      = step_r;
    if (cmd.accept) begin
      step_nxt = '0;
      if (is_text) begin
        line_page_nxt = pg_eff;
        cursor_nxt    = draw_go ? cur_adv[7:0] : cur_eff;
        // A character that leaves no room for another closes the line.
        line_open_nxt = draw_go && (cur_adv <= LAST_CELL_9);
        addr_nxt      = draw_base;
      end else if (in_data.req_type == REQ_READ) begin
        addr_nxt = read_addr;
      end else begin
        addr_nxt = '0;
      end
    end else if (cmd.mem_clear) begin
      addr_nxt = addr_r + ADDR_W'(1);
    end else if (cmd.mem_draw) begin
      addr_nxt = addr_r + ADDR_W'(1);
      step_nxt = step_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r    <= '0;
      line_page_r <= '0;
      line_open_r <= 1'b0;
      addr_r      <= '0;
      step_r      <= '0;
    end else begin
      cursor_r    <= cursor_nxt;
      line_page_r <= line_page_nxt;
      line_open_r <= line_open_nxt;
      addr_r      <= addr_nxt;
      step_r      <= step_nxt;
    end
  end

  // Result payload and glyph shifter; the glyph empties to zero for the spacer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      glyph_r <= font_glyph(font_row_of(in_data.char_code));
      drawn_r <= draw_go;
      rd_ok_r <= (in_data.req_type == REQ_READ) && rd_ok;
    end else if (cmd.mem_draw) begin
      glyph_r <= {glyph_r[GLYPH_BITS-9:0], 8'h00};
    end
    if (cmd.out_load) begin
      out_data_r.read_data <= rd_ok_r ? mem_q_r : 8'd0;
      out_data_r.drawn     <= drawn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_clear) begin
      mem[addr_r] <= 8'd0;
    end else if (cmd.mem_draw) begin
      mem[addr_r] <= glyph_r[GLYPH_BITS-1 -: 8];
    end
    if (cmd.mem_read) begin
      mem_q_r <= mem[addr_r];
    end
  end

  always_comb begin
    status.draw_go    = draw_go;
    status.is_clear   = (in_data.req_type == REQ_CLEAR);
    status.is_read    = (in_data.req_type == REQ_READ);
    status.sweep_last = (addr_r == ADDR_W'(STORE_BYTES - 1));
    status.cell_last  = (step_r == STEP_W'(CELL_WIDTH - 1));
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ===== design/ttp_ctrl.sv =====
// Controller state machine of the text-to-page frame buffer: sequences store
// sweeps, cell writes and reads, and owns both handshakes. Depends on ttp_pkg.
`default_nettype none

module ttp_ctrl
  import ttp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_DRAW  = 6'b001000,
    S_READ  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_INIT: begin
        cmd.mem_clear = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.draw_go) begin
            state_nxt = S_DRAW;
          end else if (status.is_clear) begin
            state_nxt = S_CLEAR;
          end else if (status.is_read) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_CLEAR: begin
        cmd.mem_clear = 1'b1;
        if (status.sweep_last) begin
          state_nxt = S_FIN;
        end
      end
      S_DRAW: begin
        cmd.mem_draw = 1'b1;
        if (status.cell_last) begin
          state_nxt = S_FIN;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== design/text_to_page_framebuffer_unit.sv =====
// Top level of the text-to-page frame buffer: page-organized monochrome store
// with a built-in 5x7 font. Depends on ttp_pkg, ttp_ctrl and ttp_datapath.
//
//   Channel   Ports                           Carries
//   -------   -----------------------------   ----------------------------------
//   in        in_valid, in_ready, in_data     one request (text, clear or read)
//   out       out_valid, out_ready, out_data  one result per request
//
// A text request is accepted, then makes six single-byte writes into the
// single-port frame store (five glyph columns and a blank spacer), and then
// hands over the result. A read makes one store read, a request that changes
// no byte goes straight to the hand-over, and a clear sweeps all 1024 bytes.
// After reset the same sweep runs with in_ready low.
// Stalls on the result side are absorbed by the output register: a transaction
// can be accepted while the previous result still waits, and it finishes only
// once that result has been taken.
`default_nettype none

module text_to_page_framebuffer_unit
  import ttp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences every transaction; it never touches payload bits.
  ttp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath decodes the offered request, keeps the open text line, and
  // holds the frame store and the result register.
  ttp_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
